### rtl/vdib_pkg.sv
// ---------------------------------------------------------------------------
// vdib_pkg: shared types and constants of the vertex dedup index builder
// field widths, opcodes, controller states, command and status groups
// ---------------------------------------------------------------------------
`default_nettype none

package vdib_pkg;

    localparam int KEY_W       = 10;
    localparam int WORD_W      = 32;
    localparam int IDX_W       = 10;
    localparam int CFG_W       = 4;
    localparam int DATA_W      = 32;
    localparam int ADDR_W      = 3;

    localparam int DEF_MAX_VERTICES = 1024;
    localparam int DEF_MAX_KEYS     = 1024;
    localparam int DEF_WORDS_MAX    = 8;

    localparam int WORDS_RESET = 8;
    localparam int WORDS_MIN   = 3;

    localparam logic OP_ADD   = 1'b0;
    localparam logic OP_CLEAR = 1'b1;

    localparam logic [ADDR_W-1:0] REG_VERTEX_WORDS = 3'd0;

    typedef enum logic [3:0] {
        ST_INIT,
        ST_IDLE,
        ST_KEY,
        ST_HEAD,
        ST_CMP,
        ST_APPEND,
        ST_LINK,
        ST_CLR,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic load_in;
        logic key_sub;
        logic latch_head;
        logic load_head;
        logic load_next;
        logic set_match;
        logic append;
        logic link;
        logic inc_count;
        logic set_full;
        logic clr_start;
        logic clr_step;
        logic set_clear_res;
        logic push;
    } t_cmd;

    typedef struct packed {
        logic in_valid;
        logic in_clear;
        logic key_big;
        logic head_valid;
        logic match;
        logic next_valid;
        logic hv_latched;
        logic full;
        logic clr_last;
        logic slot_free;
    } t_status;

endpackage

`default_nettype wire

### rtl/vdib_if.sv
// ---------------------------------------------------------------------------
// vdib_if: stream channels of the vertex dedup index builder
// request channel and result channel, valid/ready handshake
// ---------------------------------------------------------------------------
`default_nettype none

interface vdib_in_if;
    import vdib_pkg::*;
    logic              valid;
    logic              ready;
    logic              opcode;
    logic [KEY_W-1:0]  position_key;
    logic [WORD_W-1:0] word0;
    logic [WORD_W-1:0] word1;
    logic [WORD_W-1:0] word2;
    logic [WORD_W-1:0] word3;
    logic [WORD_W-1:0] word4;
    logic [WORD_W-1:0] word5;
    logic [WORD_W-1:0] word6;
    logic [WORD_W-1:0] word7;

    modport source (output valid, opcode, position_key, word0, word1, word2, word3,
                    word4, word5, word6, word7, input ready);
    modport sink (input valid, opcode, position_key, word0, word1, word2, word3,
                  word4, word5, word6, word7, output ready);
endinterface

interface vdib_out_if;
    import vdib_pkg::*;
    logic             valid;
    logic             ready;
    logic [IDX_W-1:0] vertex_index;
    logic             is_new;
    logic             table_full;

    modport source (output valid, vertex_index, is_new, table_full, input ready);
    modport sink (input valid, vertex_index, is_new, table_full, output ready);
endinterface

`default_nettype wire

### rtl/vertex_dedup_index_builder.sv
// ---------------------------------------------------------------------------
// vertex_dedup_index_builder: indexed vertex list builder
// dedups vertices per position key and hands back their store index
// ---------------------------------------------------------------------------
// One request at a time, one stored vertex compared per cycle through the
// vertex store read port. A request is taken in idle, its key reduced, the
// head of its key's chain looked up and the chain walked entry by entry
// until a match or its end; a miss appends the new vertex unless the store
// is full, with a link step when the new vertex joins an existing chain. A
// key at or past MAX_KEYS is reduced by subtracting MAX_KEYS repeatedly. A
// clear request sweeps the key table, and reset runs a sweep over the key
// table during which no request is taken. A result waits in an output
// register, so the next request can start while it does; only a second
// result that finds that register still full holds the sequencer in its
// last state until the waiting beat is taken.
// ---------------------------------------------------------------------------
`default_nettype none

module vertex_dedup_index_builder
    import vdib_pkg::*;
#(
    parameter int MAX_VERTICES = DEF_MAX_VERTICES,
    parameter int MAX_KEYS     = DEF_MAX_KEYS,
    parameter int WORDS_MAX    = DEF_WORDS_MAX
) (
    input  wire               i_clk,
    input  wire               i_rst_n,
    vdib_in_if.sink           i_in,
    vdib_out_if.source        o_out,
    input  wire               psel,
    input  wire               penable,
    input  wire               pwrite,
    input  wire  [ADDR_W-1:0] paddr,
    input  wire  [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready
);

    // configuration: one register, the word count
    logic [CFG_W-1:0] r_vertex_words;
    t_cmd             w_cmd;
    t_status          w_status;
    logic             w_in_ready;

    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vertex_words <= CFG_W'(WORDS_RESET);
        end else if (psel && penable && pwrite && pready
                     && paddr[ADDR_W-1:2] == REG_VERTEX_WORDS[ADDR_W-1:2]) begin
            r_vertex_words <= pwdata[CFG_W-1:0];
        end
    end

    always_comb begin
        prdata = '0;
        if (paddr[ADDR_W-1:2] == REG_VERTEX_WORDS[ADDR_W-1:2]) begin
            prdata = {{(DATA_W-CFG_W){1'b0}}, r_vertex_words};
        end
    end

    assign i_in.ready = w_in_ready;

    vdib_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_status   (w_status),
        .o_cmd      (w_cmd),
        .o_in_ready (w_in_ready)
    );

    vdib_dp #(
        .MAX_VERTICES (MAX_VERTICES),
        .MAX_KEYS     (MAX_KEYS),
        .WORDS_MAX    (WORDS_MAX)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_vertex_words (r_vertex_words),
        .i_cmd          (w_cmd),
        .o_status       (w_status),
        .i_in           (i_in),
        .o_out          (o_out)
    );

endmodule

`default_nettype wire

### rtl/vdib_ctrl.sv
// ---------------------------------------------------------------------------
// vdib_ctrl: sequencer of the vertex dedup index builder
// steps key reduction, chain walk, append, link and clear sweep
// ---------------------------------------------------------------------------
`default_nettype none

module vdib_ctrl
    import vdib_pkg::*;
(
    input  wire     i_clk,
    input  wire     i_rst_n,
    input  t_status i_status,
    output t_cmd    o_cmd,
    output logic    o_in_ready
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_INIT;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_INIT: begin
                if (i_status.clr_last) n_state = ST_IDLE;
            end
            ST_IDLE: begin
                if (i_status.in_valid) n_state = i_status.in_clear ? ST_CLR : ST_KEY;
            end
            ST_KEY: begin
                if (!i_status.key_big) n_state = ST_HEAD;
            end
            ST_HEAD: begin
                n_state = i_status.head_valid ? ST_CMP : ST_APPEND;
            end
            ST_CMP: begin
                priority if (i_status.match) n_state = ST_DONE;
                else if (i_status.next_valid) n_state = ST_CMP;
                else n_state = ST_APPEND;
            end
            ST_APPEND: begin
                priority if (i_status.full) n_state = ST_DONE;
                else if (i_status.hv_latched) n_state = ST_LINK;
                else n_state = ST_DONE;
            end
            ST_LINK: n_state = ST_DONE;
            ST_CLR: begin
                if (i_status.clr_last) n_state = ST_DONE;
            end
            ST_DONE: begin
                if (i_status.slot_free) n_state = ST_IDLE;
            end
            default: n_state = ST_INIT;
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            ST_INIT: o_cmd.clr_step = 1'b1;
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_status.in_valid) begin
                    o_cmd.load_in   = 1'b1;
                    o_cmd.clr_start = i_status.in_clear;
                end
            end
            ST_KEY: o_cmd.key_sub = i_status.key_big;
            ST_HEAD: begin
                o_cmd.latch_head = 1'b1;
                o_cmd.load_head  = i_status.head_valid;
            end
            ST_CMP: begin
                priority if (i_status.match) o_cmd.set_match = 1'b1;
                else if (i_status.next_valid) o_cmd.load_next = 1'b1;
                else o_cmd.set_match = 1'b0;
            end
            ST_APPEND: begin
                priority if (i_status.full) begin
                    o_cmd.set_full = 1'b1;
                end else begin
                    o_cmd.append    = 1'b1;
                    o_cmd.inc_count = !i_status.hv_latched;
                end
            end
            ST_LINK: begin
                o_cmd.link      = 1'b1;
                o_cmd.inc_count = 1'b1;
            end
            ST_CLR: begin
                o_cmd.clr_step      = 1'b1;
                o_cmd.set_clear_res = i_status.clr_last;
            end
            ST_DONE: o_cmd.push = i_status.slot_free;
            default: o_cmd = '0;
        endcase
    end

    // a new item is taken only with the sequencer at rest
    a_ready_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_ready |-> r_state == ST_IDLE && !o_cmd.push)
        else $error("ready outside idle");
    // a link always follows the append of the same item
    a_link_after_append: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.link |-> $past(o_cmd.append))
        else $error("link without append");
    // every item ends in exactly one push before the next is taken
    a_done_push: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DONE && i_status.slot_free) |=> r_state == ST_IDLE)
        else $error("result not pushed");

endmodule

`default_nettype wire

### rtl/vdib_dp.sv
// ---------------------------------------------------------------------------
// vdib_dp: datapath of the vertex dedup index builder
// vertex store, per-key head/tail table, chain links, result register
// ---------------------------------------------------------------------------
`default_nettype none

module vdib_dp
    import vdib_pkg::*;
#(
    parameter int MAX_VERTICES = DEF_MAX_VERTICES,
    parameter int MAX_KEYS     = DEF_MAX_KEYS,
    parameter int WORDS_MAX    = DEF_WORDS_MAX
) (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire [CFG_W-1:0]  i_vertex_words,
    input  t_cmd             i_cmd,
    output t_status          o_status,
    vdib_in_if.sink          i_in,
    vdib_out_if.source       o_out
);

    localparam int VW  = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
    localparam int CW  = $clog2(MAX_VERTICES + 1);
    localparam int KW  = (MAX_KEYS > 1) ? $clog2(MAX_KEYS) : 1;
    localparam int ROW = WORDS_MAX * WORD_W;
    localparam int KMW = 1 + 2 * VW;

    // memories
    logic [ROW-1:0] r_store [MAX_VERTICES];
    logic [VW:0]    r_next  [MAX_VERTICES];
    logic [KMW-1:0] r_kmem  [MAX_KEYS];

    logic [ROW-1:0]   r_row;
    logic [VW:0]      r_nrd;
    logic [KMW-1:0]   r_krd;

    logic [KEY_W-1:0] r_key;
    logic [ROW-1:0]   r_words;
    logic [VW-1:0]    r_cur;
    logic [VW-1:0]    n_cur;
    logic             r_hv;
    logic [VW-1:0]    r_tail;
    logic [CW-1:0]    r_cnt;
    logic [KW-1:0]    r_sweep;

    logic [IDX_W-1:0] r_res_idx;
    logic             r_res_new;
    logic             r_res_full;

    logic             r_ovalid;
    logic [IDX_W-1:0] r_oidx;
    logic             r_onew;
    logic             r_ofull;

    logic [CFG_W-1:0]     w_n;
    logic [WORDS_MAX-1:0] w_mask;
    logic [WORDS_MAX-1:0] w_eq;
    logic [ROW-1:0]       w_in_row;
    logic [WORD_W-1:0]    w_in_word [8];
    logic [KW-1:0]        w_key_idx;
    logic [VW-1:0]        w_new_idx;
    logic                 w_full;

    assign w_in_word[0] = i_in.word0;
    assign w_in_word[1] = i_in.word1;
    assign w_in_word[2] = i_in.word2;
    assign w_in_word[3] = i_in.word3;
    assign w_in_word[4] = i_in.word4;
    assign w_in_word[5] = i_in.word5;
    assign w_in_word[6] = i_in.word6;
    assign w_in_word[7] = i_in.word7;

    // word count clamped into the supported range
    always_comb begin
        priority if (i_vertex_words < CFG_W'(WORDS_MIN)) w_n = CFG_W'(WORDS_MIN);
        else if (i_vertex_words > CFG_W'(WORDS_MAX)) w_n = CFG_W'(WORDS_MAX);
        else w_n = i_vertex_words;
    end

    always_comb begin
        for (int i = 0; i < WORDS_MAX; i++) begin
            w_mask[i] = (CFG_W'(i) < w_n);
            w_in_row[i*WORD_W +: WORD_W] = w_mask[i] ? w_in_word[i] : '0;
            w_eq[i] = (r_row[i*WORD_W +: WORD_W] == r_words[i*WORD_W +: WORD_W]);
        end
    end

    assign w_key_idx = KW'(r_key);
    assign w_new_idx = VW'(r_cnt);
    assign w_full    = (r_cnt >= CW'(MAX_VERTICES));

    always_comb begin
        priority if (i_cmd.load_head) n_cur = r_krd[2*VW-1:VW];
        else if (i_cmd.load_next) n_cur = r_nrd[VW-1:0];
        else n_cur = r_cur;
    end

    // request and walk registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_key   <= i_in.position_key;
            r_words <= w_in_row;
        end else if (i_cmd.key_sub) begin
            r_key <= r_key - KEY_W'(MAX_KEYS);
        end
        if (i_cmd.latch_head) begin
            r_hv   <= r_krd[KMW-1];
            r_tail <= r_krd[VW-1:0];
        end
        r_cur <= n_cur;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt   <= '0;
            r_sweep <= '0;
        end else begin
            if (i_cmd.clr_start) begin
                r_cnt   <= '0;
                r_sweep <= '0;
            end else begin
                if (i_cmd.inc_count) r_cnt <= r_cnt + CW'(1);
                if (i_cmd.clr_step) r_sweep <= r_sweep + KW'(1);
            end
        end
    end

    // vertex store and chain links
    always_ff @(posedge i_clk) begin
        if (i_cmd.append) r_store[w_new_idx] <= r_words;
        r_row <= r_store[n_cur];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.append) begin
            r_next[w_new_idx] <= '0;
        end else if (i_cmd.link) begin
            r_next[r_tail] <= {1'b1, w_new_idx};
        end
        r_nrd <= r_next[n_cur];
    end

    // per-key head and tail
    always_ff @(posedge i_clk) begin
        if (i_cmd.clr_step) begin
            r_kmem[r_sweep] <= '0;
        end else if (i_cmd.append) begin
            r_kmem[w_key_idx] <= r_hv ? {1'b1, r_krd[2*VW-1:VW], w_new_idx}
                                      : {1'b1, w_new_idx, w_new_idx};
        end
        r_krd <= r_kmem[w_key_idx];
    end

    // result staging
    always_ff @(posedge i_clk) begin
        priority if (i_cmd.set_match) begin
            r_res_idx  <= IDX_W'(r_cur);
            r_res_new  <= 1'b0;
            r_res_full <= 1'b0;
        end else if (i_cmd.append) begin
            r_res_idx  <= IDX_W'(w_new_idx);
            r_res_new  <= 1'b1;
            r_res_full <= 1'b0;
        end else if (i_cmd.set_full) begin
            r_res_idx  <= '0;
            r_res_new  <= 1'b0;
            r_res_full <= 1'b1;
        end else if (i_cmd.set_clear_res) begin
            r_res_idx  <= '0;
            r_res_new  <= 1'b0;
            r_res_full <= 1'b0;
        end else begin
            r_res_idx <= r_res_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (i_cmd.push) begin
            r_ovalid <= 1'b1;
        end else if (o_out.ready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.push) begin
            r_oidx  <= r_res_idx;
            r_onew  <= r_res_new;
            r_ofull <= r_res_full;
        end
    end

    assign o_out.valid        = r_ovalid;
    assign o_out.vertex_index = r_oidx;
    assign o_out.is_new       = r_onew;
    assign o_out.table_full   = r_ofull;

    always_comb begin
        o_status            = '0;
        o_status.in_valid   = i_in.valid;
        o_status.in_clear   = (i_in.opcode == OP_CLEAR);
        o_status.key_big    = ({22'd0, r_key} >= MAX_KEYS);
        o_status.head_valid = r_krd[KMW-1];
        o_status.match      = &(w_eq | ~w_mask);
        o_status.next_valid = r_nrd[VW];
        o_status.hv_latched = r_hv;
        o_status.full       = w_full;
        o_status.clr_last   = (r_sweep == KW'(MAX_KEYS - 1));
        o_status.slot_free  = !r_ovalid || o_out.ready;
    end

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CW'(MAX_VERTICES))
        else $error("vertex count past store depth");
    a_append_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.append |-> !w_full)
        else $error("append into a full store");
    a_push_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.push |-> (!r_ovalid || o_out.ready))
        else $error("result overwritten");

endmodule

`default_nettype wire
